### hw/rtl/biu_pkg.sv
`timescale 1ns / 1ps

package biu_pkg;

   // field and datapath widths
   localparam int SIDE_W   = 8;
   localparam int SCALE_W  = 7;
   localparam int MARGIN_W = 8;
   localparam int CNT_W    = 16;
   localparam int PIX_W    = 16;
   localparam int BYTE_W   = 13;
   localparam int IDX_W    = 17;

   // register indexes
   localparam logic [1:0] CSR_SIDE   = 2'd0;
   localparam logic [1:0] CSR_SCALE  = 2'd1;
   localparam logic [1:0] CSR_MARGIN = 2'd2;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_MISMATCH = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;

   // register reset values and what follows from them
   localparam logic [SIDE_W-1:0]   RST_SIDE   = 8'd21;
   localparam logic [SCALE_W-1:0]  RST_SCALE  = 7'd1;
   localparam logic [MARGIN_W-1:0] RST_MARGIN = 8'd4;
   localparam logic [PIX_W-1:0]    RST_BAND   = 16'd21;
   localparam logic [PIX_W-1:0]    RST_WIDTH  = 16'd29;
   localparam logic [CNT_W-1:0]    RST_NEED   = 16'd441;

   localparam logic [CNT_W-1:0]    LOAD_SAT   = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BITS,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic wr_bit;
      logic rd_en;
   } ram_ctl_type;

endpackage

### hw/rtl/biu_bit_ram.sv
`timescale 1ns / 1ps

module biu_bit_ram #(
   parameter int DEPTH = 32768,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  biu_pkg::ram_ctl_type    ctl,
   input  logic [AW-1:0]           wr_addr,
   input  logic [AW-1:0]           rd_addr,
   output logic                    rd_bit
);
   import biu_pkg::*;

   logic mem [DEPTH];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_bit;
      end
      if (ctl.rd_en) begin
         rd_bit_ff <= mem[rd_addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

### hw/rtl/bilevel_image_upscale_margin.sv
`timescale 1ns / 1ps

// bilevel image upscaler with margin, one bit per pixel
// channels: command words on req_* (start/busy), result words on rsp_* marked
//   by the one-cycle rsp_valid strobe, register writes on csr_* (valid/ready)
// load word (req_cmd = 0): bit 0 of req_module_req goes into the module store
//   at the next raster index; written at the accepting edge, busy stays low
// pull word (req_cmd = 1): returns the next packed image byte, msb first
//   first pull of an image: a check state first, then as any other pull; a
//   count mismatch or an empty image ends it there with an error word
//   other pulls: eight reads on the single-bit store port (one pixel per
//   cycle), a drain state for the last registered read, a finish state to
//   register the byte and update the raster position; the strobe cycle is
//   already idle, so the next pull can be taken while the byte is shown
// the receiver cannot stall: each result is shown for exactly one cycle
// reset: registers go to side 21, scale 1, margin 4, load count and raster
//   position clear; store contents are undefined and not cleared
// csr writes are taken only while idle and start is low; a write to a defined
//   register ends an image readout in progress (the load is kept)
module bilevel_image_upscale_margin #(
   parameter int MAX_MODULES = 32768
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [7:0]                      req_module_req,
   // result channel
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_pixel_byte,
   output logic                            rsp_last_byte,
   output logic [1:0]                      rsp_status,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [7:0]                      csr_data
);
   import biu_pkg::*;

   localparam int AW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_MODULES);

   // control state
   state_type              state_ff, state_in;
   logic [2:0]             bit_cnt_ff, bit_cnt_in;
   logic                   pend_ff, pend_in;
   logic                   emitting_ff, emitting_in;
   logic [CNT_W-1:0]       load_count_ff, load_count_in;

   // configuration and derived geometry
   logic [SIDE_W-1:0]      side_ff, side_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [MARGIN_W-1:0]    margin_ff, margin_in;
   logic [PIX_W-1:0]       band_ff, band_in;
   logic [PIX_W-1:0]       width_ff, width_in;
   logic [CNT_W-1:0]       need_ff, need_in;

   // raster position
   logic [PIX_W-1:0]       out_row_ff, out_row_in;
   logic [BYTE_W-1:0]      out_column_ff, out_column_in;
   logic [SCALE_W-1:0]     row_repeat_ff, row_repeat_in;
   logic [CNT_W-1:0]       row_base_ff, row_base_in;
   logic [PIX_W-1:0]       x_ff, x_in;
   logic [SIDE_W-1:0]      hcol_ff, hcol_in;
   logic [SCALE_W-1:0]     hrep_ff, hrep_in;

   // byte assembly
   logic                   take_ff, take_in;
   logic [7:0]             sh_ff, sh_in;

   // result word
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_pixel_byte_ff, rsp_pixel_byte_in;
   logic                   rsp_last_byte_ff, rsp_last_byte_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   // store port
   ram_ctl_type            ram_ctl;
   logic [AW-1:0]          ram_wr_addr;
   logic [AW-1:0]          ram_rd_addr;
   logic                   ram_rd_bit;

   // combinational helpers
   logic                   req_fire;
   logic                   csr_fire;
   logic                   chk_mismatch;
   logic                   chk_empty;
   logic                   row_in_band;
   logic                   x_in_band;
   logic [IDX_W-1:0]       rd_idx;
   logic [BYTE_W-1:0]      line_bytes;
   logic                   row_end;
   logic                   last;
   logic [CNT_W-1:0]       wr_base;

   assign req_fire = start && !busy;
   assign csr_fire = csr_valid && csr_ready;

   // derived geometry, registered in the cycle after the registers change
   assign band_in  = PIX_W'(scale_ff * side_ff);
   assign width_in = PIX_W'({margin_ff, 1'b0}) + band_in;
   assign need_in  = CNT_W'(side_ff * side_ff);

   assign line_bytes   = BYTE_W'((17'(width_ff) + 17'd7) >> 3);
   assign chk_mismatch = (load_count_ff != need_ff) || ({1'b0, need_ff} > MAX_IDX);
   assign chk_empty    = (width_ff == '0);

   assign row_in_band = (out_row_ff >= PIX_W'(margin_ff))
                     && ((out_row_ff - PIX_W'(margin_ff)) < band_ff);
   assign x_in_band   = (x_ff < width_ff) && (x_ff >= PIX_W'(margin_ff))
                     && ((x_ff - PIX_W'(margin_ff)) < band_ff);
   assign rd_idx      = {1'b0, row_base_ff} + IDX_W'(hcol_ff);
   assign ram_rd_addr = rd_idx[AW-1:0];

   assign row_end = (14'(out_column_ff) + 14'd1) >= 14'(line_bytes);
   assign last    = ((17'(out_row_ff) + 17'd1) >= 17'(width_ff)) && row_end;

   assign wr_base     = emitting_ff ? '0 : load_count_ff;
   assign ram_wr_addr = wr_base[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_PULL) begin
               state_in = emitting_ff ? ST_BITS : ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (chk_mismatch || chk_empty) ? ST_IDLE : ST_BITS;
         end
         ST_BITS: begin
            if (bit_cnt_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      // a pending command word goes ahead of a register write
      csr_ready     = (state_ff == ST_IDLE) && !start;
      ram_ctl.rd_en = (state_ff == ST_BITS);
      pend_in       = (state_ff == ST_BITS);
      ram_ctl.wr_en = req_fire && (req_cmd == CMD_LOAD) && ({1'b0, wr_base} < MAX_IDX);
      ram_ctl.wr_bit = req_module_req[0];
   end

   // datapath
   always_comb begin
      side_in           = side_ff;
      scale_in          = scale_ff;
      margin_in         = margin_ff;
      emitting_in       = emitting_ff;
      load_count_in     = load_count_ff;
      out_row_in        = out_row_ff;
      out_column_in     = out_column_ff;
      row_repeat_in     = row_repeat_ff;
      row_base_in       = row_base_ff;
      x_in              = x_ff;
      hcol_in           = hcol_ff;
      hrep_in           = hrep_ff;
      bit_cnt_in        = bit_cnt_ff;
      take_in           = take_ff;
      sh_in             = sh_ff;
      rsp_valid_in      = 1'b0;
      rsp_pixel_byte_in = rsp_pixel_byte_ff;
      rsp_last_byte_in  = rsp_last_byte_ff;
      rsp_status_in     = rsp_status_ff;

      // registered read comes back in the cycle after its address
      if (pend_ff) begin
         sh_in = {sh_ff[6:0], take_ff & ram_rd_bit};
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               case (csr_index)
                  CSR_SIDE:   side_in   = csr_data;
                  CSR_SCALE:  scale_in  = csr_data[SCALE_W-1:0];
                  CSR_MARGIN: margin_in = csr_data;
                  default:    ;
               endcase
               if (csr_index == CSR_SIDE || csr_index == CSR_SCALE
                   || csr_index == CSR_MARGIN) begin
                  // readout ends, the load stays
                  emitting_in   = 1'b0;
                  out_row_in    = '0;
                  out_column_in = '0;
                  row_repeat_in = '0;
                  row_base_in   = '0;
                  x_in          = '0;
                  hcol_in       = '0;
                  hrep_in       = '0;
               end
            end
            if (req_fire) begin
               bit_cnt_in = '0;
               if (req_cmd == CMD_LOAD) begin
                  // a load during readout restarts the load at index zero
                  emitting_in   = 1'b0;
                  out_row_in    = '0;
                  out_column_in = '0;
                  row_repeat_in = '0;
                  row_base_in   = '0;
                  x_in          = '0;
                  hcol_in       = '0;
                  hrep_in       = '0;
                  load_count_in = (wr_base != LOAD_SAT) ? wr_base + 1'b1 : wr_base;
               end
            end
         end
         ST_CHECK: begin
            bit_cnt_in = '0;
            if (chk_mismatch || chk_empty) begin
               load_count_in     = '0;
               rsp_valid_in      = 1'b1;
               rsp_pixel_byte_in = '0;
               rsp_last_byte_in  = 1'b0;
               rsp_status_in     = chk_mismatch ? STAT_MISMATCH : STAT_EMPTY;
            end else begin
               emitting_in   = 1'b1;
               out_row_in    = '0;
               out_column_in = '0;
               row_repeat_in = '0;
               row_base_in   = '0;
               x_in          = '0;
               hcol_in       = '0;
               hrep_in       = '0;
            end
         end
         ST_BITS: begin
            // one pixel per cycle through the single read port
            take_in    = row_in_band && x_in_band && (rd_idx < MAX_IDX);
            bit_cnt_in = bit_cnt_ff + 3'd1;
            x_in       = x_ff + 1'b1;
            if (x_in_band) begin
               if ((8'(hrep_ff) + 8'd1) >= 8'(scale_ff)) begin
                  hrep_in = '0;
                  hcol_in = hcol_ff + 1'b1;
               end else begin
                  hrep_in = hrep_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            rsp_valid_in      = 1'b1;
            rsp_pixel_byte_in = sh_ff;
            rsp_last_byte_in  = last;
            rsp_status_in     = STAT_OK;
            if (row_end) begin
               out_column_in = '0;
               out_row_in    = out_row_ff + 1'b1;
               x_in          = '0;
               hcol_in       = '0;
               hrep_in       = '0;
               if (row_in_band) begin
                  if ((8'(row_repeat_ff) + 8'd1) >= 8'(scale_ff)) begin
                     row_repeat_in = '0;
                     row_base_in   = row_base_ff + CNT_W'(side_ff);
                  end else begin
                     row_repeat_in = row_repeat_ff + 1'b1;
                  end
               end
            end else begin
               out_column_in = out_column_ff + 1'b1;
            end
            if (last) begin
               emitting_in   = 1'b0;
               load_count_in = '0;
               out_row_in    = '0;
               out_column_in = '0;
               row_repeat_in = '0;
               row_base_in   = '0;
               x_in          = '0;
               hcol_in       = '0;
               hrep_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_cnt_ff    <= '0;
         pend_ff       <= 1'b0;
         emitting_ff   <= 1'b0;
         load_count_ff <= '0;
         side_ff       <= RST_SIDE;
         scale_ff      <= RST_SCALE;
         margin_ff     <= RST_MARGIN;
         band_ff       <= RST_BAND;
         width_ff      <= RST_WIDTH;
         need_ff       <= RST_NEED;
         out_row_ff    <= '0;
         out_column_ff <= '0;
         row_repeat_ff <= '0;
         row_base_ff   <= '0;
         x_ff          <= '0;
         hcol_ff       <= '0;
         hrep_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_cnt_ff    <= bit_cnt_in;
         pend_ff       <= pend_in;
         emitting_ff   <= emitting_in;
         load_count_ff <= load_count_in;
         side_ff       <= side_in;
         scale_ff      <= scale_in;
         margin_ff     <= margin_in;
         band_ff       <= band_in;
         width_ff      <= width_in;
         need_ff       <= need_in;
         out_row_ff    <= out_row_in;
         out_column_ff <= out_column_in;
         row_repeat_ff <= row_repeat_in;
         row_base_ff   <= row_base_in;
         x_ff          <= x_in;
         hcol_ff       <= hcol_in;
         hrep_ff       <= hrep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      take_ff           <= take_in;
      sh_ff             <= sh_in;
      rsp_pixel_byte_ff <= rsp_pixel_byte_in;
      rsp_last_byte_ff  <= rsp_last_byte_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;
   assign rsp_status     = rsp_status_ff;

   // single-bit module store
   biu_bit_ram #(
      .DEPTH   (MAX_MODULES),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .rd_addr (ram_rd_addr),
      .rd_bit  (ram_rd_bit)
   );

   // a result word only follows a busy cycle of the sequencer
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without preceding work");

   // error words carry no pixels
   a_err_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_pixel_byte == '0 && !rsp_last_byte))
      else $error("error word carries pixel data");

   // pixel reads happen only inside an image readout
   a_bits_emitting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS) |-> emitting_ff)
      else $error("pixel read outside readout");

   // the final byte ends the readout and consumes the load
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (!emitting_ff && load_count_ff == '0))
      else $error("readout still open after final byte");

   // the sequencer walks exactly eight pixels per byte
   a_eight_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> ($past(state_ff) == ST_BITS && $past(bit_cnt_ff) == 3'd7))
      else $error("byte assembled from wrong pixel count");

endmodule
